### rtl/running_mean_moment_table_top_assert.svh
// Assertion macros shared by the running mean table RTL.
`ifndef RUNNING_MEAN_MOMENT_TABLE_TOP_ASSERT_SVH
`define RUNNING_MEAN_MOMENT_TABLE_TOP_ASSERT_SVH

// Clocked implication or expression check, idle during reset.
`define RMM_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmm assertion failed");

// Condition that must never be seen at a clock edge.
`define RMM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("rmm forbidden condition seen");

`endif

### rtl/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Types and fixed constants shared by the running mean table modules.
// ----------------------------------------------------------------------------
package rmm_pkg;

  localparam int VAL_W    = 64;
  localparam int CNT_W    = 32;
  localparam int SLOT_W   = 2;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = 7;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic ACT_ARITH  = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  // square partial product steps
  localparam logic [1:0] SQ_LL = 2'd0;
  localparam logic [1:0] SQ_LH = 2'd1;
  localparam logic [1:0] SQ_HH = 2'd2;

  localparam logic [SLOT_W-1:0] SLOT_LAST_ARITH  = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_LAST_SELECT = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_FINISH,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic              idle;
    logic              take;
    logic              clear_wr;
    logic              rd_en;
    logic              sq_en;
    logic [1:0]        sq_step;
    logic              prep;
    logic              div_start;
    logic              finish;
    logic              commit;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic key_ok;
    logic action;
    logic clear_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### rtl/rmm_ram.sv
// ----------------------------------------------------------------------------
// rmm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmm_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rmm_div.sv
// ----------------------------------------------------------------------------
// rmm_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module rmm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rmm_pkg::VAL_W-1:0]  dividend_i,
  input  logic [rmm_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [rmm_pkg::VAL_W-1:0]  quotient_o
);
  import rmm_pkg::*;

  logic [VAL_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [CNT_W:0]       shifted;
  logic                 ge;

  always_comb begin
    shifted = {rem_q, quo_q[VAL_W-1]};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = ge ? CNT_W'(shifted - {1'b0, dsr_q}) : shifted[CNT_W-1:0];
    quo_d   = {quo_q[VAL_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/rmm_ctrl.sv
// ----------------------------------------------------------------------------
// rmm_ctrl
// Sequencer: clear sweep, item intake and the per-slot update steps.
// ----------------------------------------------------------------------------
`include "running_mean_moment_table_top_assert.svh"

module rmm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rmm_pkg::status_t status_i,
  output rmm_pkg::cmd_t    cmd_o
);
  import rmm_pkg::*;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q;
  logic [1:0]        step_q;
  logic              last_slot;

  assign last_slot = (status_i.action == ACT_SELECT) ? (slot_q == SLOT_LAST_SELECT)
                                                     : (slot_q == SLOT_LAST_ARITH);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i && status_i.key_ok) state_d = ST_READ;
      ST_READ:   state_d = ST_SQUARE;
      ST_SQUARE: if (step_q == SQ_HH) state_d = ST_PREP;
      ST_PREP:   state_d = ST_START;
      ST_START:  state_d = ST_DIV;
      ST_DIV:    if (status_i.div_done) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_WRITE;
      ST_WRITE: begin
        if (status_i.out_free) state_d = last_slot ? ST_IDLE : ST_READ;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.slot      = slot_q;
    cmd_o.sq_step   = step_q;
    cmd_o.idle      = (state_q == ST_IDLE);
    cmd_o.take      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clear_wr  = (state_q == ST_CLEAR);
    cmd_o.rd_en     = (state_q == ST_READ);
    cmd_o.sq_en     = (state_q == ST_SQUARE);
    cmd_o.prep      = (state_q == ST_PREP);
    cmd_o.div_start = (state_q == ST_START);
    cmd_o.finish    = (state_q == ST_FINISH);
    cmd_o.commit    = (state_q == ST_WRITE) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      slot_q  <= '0;
      step_q  <= SQ_LL;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        slot_q <= '0;
      end else if (state_q == ST_WRITE && status_i.out_free && !last_slot) begin
        slot_q <= slot_q + 1'b1;
      end
      if (state_q == ST_READ) begin
        step_q <= SQ_LL;
      end else if (state_q == ST_SQUARE) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  `RMM_ASSERT_CLK(a_div_done_in_div, status_i.div_done |-> state_q == ST_DIV)
  `RMM_ASSERT_CLK(a_clear_exits, (state_q == ST_CLEAR && status_i.clear_done) |=> state_q == ST_IDLE)
  `RMM_ASSERT_NEVER(a_slot3_select_only, state_q == ST_WRITE && slot_q == SLOT_LAST_SELECT && status_i.action != ACT_SELECT)

endmodule

### rtl/rmm_datapath.sv
// ----------------------------------------------------------------------------
// rmm_datapath
// Item registers, statistics RAM, squarer, two dividers and the output stage.
// ----------------------------------------------------------------------------
module rmm_datapath #(
  parameter int SITES     = 64,
  parameter int INDICES   = 8,
  parameter int FRAC_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmm_pkg::cmd_t                     cmd_i,
  output rmm_pkg::status_t                  status_o,
  input  logic                              action_i,
  input  logic [5:0]                        site_id_i,
  input  logic [2:0]                        operand_index_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  result_value_i,
  input  logic                              condition_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  first_operand_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  second_operand_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmm_pkg::SLOT_W-1:0]        slot_o,
  output logic signed [rmm_pkg::VAL_W-1:0]  mean_value_o,
  output logic signed [rmm_pkg::VAL_W-1:0]  second_moment_o,
  output logic [rmm_pkg::CNT_W-1:0]         sample_count_o,
  output logic                              last_o
);
  import rmm_pkg::*;

  localparam int DEPTH = SITES * INDICES * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = CNT_W + 2 * VAL_W;
  localparam int HW    = VAL_W / 2;

  // latched item
  logic             action_q, cond_q;
  logic [VAL_W-1:0] res_q, op1_q, op2_q;
  logic [AW-1:0]    base_q;

  logic [AW-1:0]    clr_q, raddr, waddr;
  logic [RW-1:0]    rdata, wdata;
  logic             we;

  logic [VAL_W-1:0]   sel_v, v_q, abs_q;
  logic [HW-1:0]      mul_a, mul_b;
  logic [VAL_W-1:0]   prod;
  logic [2*VAL_W-1:0] acc_q, shifted;
  logic [VAL_W-1:0]   sq_q;
  logic [CNT_W-1:0]   n_q, cnt_old;

  logic [VAL_W-1:0] mean_cur, mom_cur, mean_diff, mom_diff;
  logic             mean_up, mom_up, mean_up_q, mom_up_q;
  logic [VAL_W-1:0] mean_quo, mom_quo, mean_new_q, mom_new_q;
  logic             mean_done, mom_done;

  logic             out_valid_q, last_q;
  logic [SLOT_W-1:0] slot_q;
  logic [VAL_W-1:0] out_mean_q, out_mom_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             is_last;

  assign status_o.key_ok     = (32'(site_id_i) < SITES) && (32'(operand_index_i) < INDICES);
  assign status_o.action     = action_q;
  assign status_o.clear_done = (clr_q == AW'(DEPTH - 1));
  assign status_o.div_done   = mean_done;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      action_q <= action_i;
      cond_q   <= condition_i;
      res_q    <= result_value_i;
      op1_q    <= first_operand_i;
      op2_q    <= second_operand_i;
      base_q   <= AW'((32'(site_id_i) * INDICES + 32'(operand_index_i)) * 4);
    end
  end

  // sweep every entry to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr && !status_o.clear_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign raddr = base_q | AW'(cmd_i.slot);
  assign waddr = cmd_i.clear_wr ? clr_q : raddr;
  assign we    = cmd_i.clear_wr || cmd_i.commit;
  assign wdata = cmd_i.clear_wr ? '0 : {n_q, mom_new_q, mean_new_q};

  rmm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // slot value
  always_comb begin
    sel_v = res_q;
    if (action_q == ACT_SELECT) begin
      unique case (cmd_i.slot)
        2'd0:    sel_v = res_q;
        2'd1:    sel_v = cond_q ? (VAL_W'(1) << FRAC_BITS) : '0;
        2'd2:    sel_v = op1_q;
        default: sel_v = op2_q;
      endcase
    end else begin
      unique case (cmd_i.slot)
        2'd0:    sel_v = res_q;
        2'd1:    sel_v = op1_q;
        default: sel_v = op2_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      v_q   <= sel_v;
      abs_q <= sel_v[VAL_W-1] ? (~sel_v + 1'b1) : sel_v;
    end
  end

  // square from three 32x32 partial products
  assign mul_a = (cmd_i.sq_step == SQ_HH) ? abs_q[VAL_W-1:HW] : abs_q[HW-1:0];
  assign mul_b = (cmd_i.sq_step == SQ_LL) ? abs_q[HW-1:0] : abs_q[VAL_W-1:HW];
  assign prod  = VAL_W'(mul_a) * VAL_W'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      unique case (cmd_i.sq_step)
        SQ_LL:   acc_q <= (2*VAL_W)'(prod);
        SQ_LH:   acc_q <= acc_q + ((2*VAL_W)'(prod) << (HW + 1));
        default: acc_q <= acc_q + ((2*VAL_W)'(prod) << VAL_W);
      endcase
    end
  end

  assign shifted = acc_q >> FRAC_BITS;
  assign cnt_old = rdata[RW-1 -: CNT_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sq_q <= (|shifted[2*VAL_W-1:VAL_W-1]) ? POS_MAX : shifted[VAL_W-1:0];
      n_q  <= (cnt_old == CNT_MAX) ? CNT_MAX : cnt_old + 1'b1;
    end
  end

  // move toward target on the exact difference
  assign mean_cur  = rdata[VAL_W-1:0];
  assign mom_cur   = rdata[2*VAL_W-1:VAL_W];
  assign mean_up   = $signed(v_q) >= $signed(mean_cur);
  assign mom_up    = $signed(sq_q) >= $signed(mom_cur);
  assign mean_diff = mean_up ? v_q - mean_cur : mean_cur - v_q;
  assign mom_diff  = mom_up ? sq_q - mom_cur : mom_cur - sq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      mean_up_q <= mean_up;
      mom_up_q  <= mom_up;
    end
  end

  rmm_div u_div_mean (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mean_diff),
    .divisor_i  (n_q),
    .done_o     (mean_done),
    .quotient_o (mean_quo)
  );

  rmm_div u_div_mom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mom_diff),
    .divisor_i  (n_q),
    .done_o     (mom_done),
    .quotient_o (mom_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mean_new_q <= mean_up_q ? mean_cur + mean_quo : mean_cur - mean_quo;
      mom_new_q  <= mom_up_q ? mom_cur + mom_quo : mom_cur - mom_quo;
    end
  end

  // output register
  assign is_last = (action_q == ACT_SELECT) ? (cmd_i.slot == SLOT_LAST_SELECT)
                                            : (cmd_i.slot == SLOT_LAST_ARITH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_q     <= cmd_i.slot;
      out_mean_q <= mean_new_q;
      out_mom_q  <= mom_new_q;
      out_cnt_q  <= n_q;
      last_q     <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_o          = slot_q;
  assign mean_value_o    = out_mean_q;
  assign second_moment_o = out_mom_q;
  assign sample_count_o  = out_cnt_q;
  assign last_o          = last_q;

  // status bit kept for symmetry checks between the two dividers
  logic div_skew;
  assign div_skew = mean_done ^ mom_done;

  `include "running_mean_moment_table_top_assert.svh"
  `RMM_ASSERT_NEVER(a_div_in_step, div_skew)
  `RMM_ASSERT_CLK(a_commit_sets_valid, cmd_i.commit |=> out_valid_q)
  `RMM_ASSERT_NEVER(a_mom_sign, cmd_i.commit && mom_new_q[VAL_W-1])

endmodule

### rtl/running_mean_moment_table_top.sv
// ----------------------------------------------------------------------------
// running_mean_moment_table_top
// Running mean and mean-of-squares table per (site, operand index, slot).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one trace event item per
//   accepted edge. An arithmetic or compare event (action 0) updates slots
//   0 to 2, a select event (action 1) updates slots 0 to 3. Events whose
//   site or operand index lies outside the table are dropped, no result.
//   Output channel out_valid_o / out_stall_i gives one item per updated
//   slot, in slot order, with last_o on the final slot of the event.
//   Each slot runs one RAM read, three 32x32 multiply steps for the
//   square, a prep and a start step, the bit-serial dividers (64 steps
//   plus the done flag, mean and moment in parallel), then finish and
//   write-back; the dividers take the longest.
//   One event keeps the input stalled until its last slot, slot 2 or
//   slot 3 for a select event, has been written back.
//   After reset all SITES*INDICES*4 table entries (2048 at the defaults)
//   are swept to zero, and no item is accepted meanwhile.
//   A finished result waits in the output register; while the receiver
//   stalls, the next slot holds before its write-back, and a new event is
//   still taken once the previous one has written its last slot.
// ----------------------------------------------------------------------------
module running_mean_moment_table_top #(
  parameter int SITES     = 64,
  parameter int INDICES   = 8,
  parameter int FRAC_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [5:0]                        site_id_i,
  input  logic [2:0]                        operand_index_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  result_value_i,
  input  logic                              condition_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  first_operand_i,
  input  logic signed [rmm_pkg::VAL_W-1:0]  second_operand_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmm_pkg::SLOT_W-1:0]        slot_o,
  output logic signed [rmm_pkg::VAL_W-1:0]  mean_value_o,
  output logic signed [rmm_pkg::VAL_W-1:0]  second_moment_o,
  output logic [rmm_pkg::CNT_W-1:0]         sample_count_o,
  output logic                              last_o
);
  import rmm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // accept only while the sequencer waits for an item
  assign in_stall_o = !cmd.idle;

  rmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmm_datapath #(
    .SITES     (SITES),
    .INDICES   (INDICES),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .action_i         (action_i),
    .site_id_i        (site_id_i),
    .operand_index_i  (operand_index_i),
    .result_value_i   (result_value_i),
    .condition_i      (condition_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .slot_o           (slot_o),
    .mean_value_o     (mean_value_o),
    .second_moment_o  (second_moment_o),
    .sample_count_o   (sample_count_o),
    .last_o           (last_o)
  );

endmodule
